/* design/ovi_pkg.sv */
// ----------------------------------------------------------------------------
// ovi_pkg
// Shared constants and codes for the octree voxel insert unit.
// ----------------------------------------------------------------------------
package ovi_pkg;

    localparam int NODE_COUNT = 4096;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int USED_W     = NODE_W + 1;
    localparam int DEPTH_MAX  = 6;
    localparam int DEPTH_W    = 3;
    localparam int LEVEL_W    = 3;
    localparam int COORD_W    = 6;
    localparam int MAT_W      = 16;
    localparam int ADDED_W    = 3;
    localparam int OCT_W      = 3;
    localparam int CHILD_AW   = NODE_W + OCT_W;

    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 32;

    typedef logic [1:0] status_t;

    localparam status_t ST_MARKED  = 2'd0;
    localparam status_t ST_RANGE   = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_CLEARED = 2'd3;

    localparam logic CMD_MARK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(DEPTH_MAX);

endpackage

/* design/octree_voxel_insert_unit.sv */
// ----------------------------------------------------------------------------
// octree_voxel_insert_unit
// Sparse voxel octree insert: walks from the root, allocates missing
// children from a bump allocator and marks the leaf solid with a material.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser = command (0 mark,
//   1 clear), tdata = voxel x, y, z and material. m_axis returns one result
//   per command: tuser = status, tdata = leaf node, nodes added, nodes used.
//   cfg_wr_en/cfg_wr_data write tree_depth; write only while idle.
//   Sequence: a mark walks one level at a time from the root (node read,
//   then evaluate/write), then writes the leaf and loads the result; a clear
//   or out-of-range command (or a full tree) skips to the result load.
//   Commands: one at a time; the next is accepted the cycle after the
//   result load, even while the result waits on tready.
//   Reset empties the tree at once (root held in flops, other nodes are
//   cleared when allocated). A stalled receiver holds the result; the walk
//   of the next command stops at its result load until the register frees.
// ----------------------------------------------------------------------------
module octree_voxel_insert_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [ovi_pkg::DEPTH_W-1:0]   cfg_wr_data,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [5:0] voxel_x, [11:6] voxel_y, [17:12] voxel_z, [33:18] material
    input  logic [ovi_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic                          s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [11:0] leaf_node, [14:12] nodes_added, [27:15] nodes_used
    output logic [ovi_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]                    m_axis_tuser
);

    localparam int NW = ovi_pkg::NODE_W;
    localparam int UW = ovi_pkg::USED_W;
    localparam int CW = ovi_pkg::COORD_W;
    localparam int LW = ovi_pkg::LEVEL_W;
    localparam int AW = ovi_pkg::ADDED_W;
    localparam int MW = ovi_pkg::MAT_W;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_MARK, S_DONE} state_t;

    // node memories
    logic [NW-1:0] child_mem    [ovi_pkg::NODE_COUNT*8];
    logic [7:0]    occ_mem      [ovi_pkg::NODE_COUNT];
    logic [NW-1:0] parent_mem   [ovi_pkg::NODE_COUNT];
    logic          solid_mem    [ovi_pkg::NODE_COUNT];
    logic [MW-1:0] material_mem [ovi_pkg::NODE_COUNT];

    state_t                     state_reg, state_next;
    logic [ovi_pkg::DEPTH_W-1:0] depth_reg;
    logic [CW-1:0]              x_reg, x_next;
    logic [CW-1:0]              y_reg, y_next;
    logic [CW-1:0]              z_reg, z_next;
    logic [MW-1:0]              mat_reg, mat_next;
    logic [LW-1:0]              level_reg, level_next;
    logic [NW-1:0]              node_reg, node_next;
    logic                       fresh_reg, fresh_next;
    logic [AW-1:0]              added_reg, added_next;
    logic [UW-1:0]              next_free_reg, next_free_next;
    logic [7:0]                 root_occ_reg, root_occ_next;
    ovi_pkg::status_t           status_reg, status_next;
    logic [NW-1:0]              leaf_reg, leaf_next;
    logic                       out_valid_reg, out_valid_next;
    logic [ovi_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    ovi_pkg::status_t           out_user_reg, out_user_next;

    logic [7:0]    occ_rd;
    logic [NW-1:0] child_rd;

    logic          occ_we;
    logic [NW-1:0] occ_waddr;
    logic [7:0]    occ_wdata;
    logic          link_we;
    logic          solid_we;
    logic [NW-1:0] solid_waddr;
    logic          solid_wdata;
    logic          mat_we;

    logic [LW-1:0]          eff_depth;
    logic [ovi_pkg::OCT_W-1:0] octant;
    logic [CW-1:0]          in_x, in_y, in_z;
    logic [MW-1:0]          in_mat;
    logic                   in_range;
    logic [7:0]             occ_cur;
    logic [7:0]             oct_bit;
    logic [NW-1:0]          new_node;
    logic                   out_free;

    assign in_x   = s_axis_tdata[CW-1:0];
    assign in_y   = s_axis_tdata[2*CW-1:CW];
    assign in_z   = s_axis_tdata[3*CW-1:2*CW];
    assign in_mat = s_axis_tdata[3*CW+MW-1:3*CW];

    always_comb
    begin
        if (depth_reg == '0)
            eff_depth = LW'(1);
        else if (depth_reg > LW'(ovi_pkg::DEPTH_MAX))
            eff_depth = LW'(ovi_pkg::DEPTH_MAX);
        else
            eff_depth = LW'(depth_reg);
    end

    assign in_range = ((in_x >> eff_depth) == '0) && ((in_y >> eff_depth) == '0)
                   && ((in_z >> eff_depth) == '0);

    assign octant   = {z_reg[level_reg], y_reg[level_reg], x_reg[level_reg]};
    assign oct_bit  = 8'(1) << octant;
    assign occ_cur  = fresh_reg ? 8'd0 : ((node_reg == '0) ? root_occ_reg : occ_rd);
    assign new_node = next_free_reg[NW-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        mat_next       = mat_reg;
        level_next     = level_reg;
        node_next      = node_reg;
        fresh_next     = fresh_reg;
        added_next     = added_reg;
        next_free_next = next_free_reg;
        root_occ_next  = root_occ_reg;
        status_next    = status_reg;
        leaf_next      = leaf_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        occ_we      = 1'b0;
        occ_waddr   = node_reg;
        occ_wdata   = 8'd0;
        link_we     = 1'b0;
        solid_we    = 1'b0;
        solid_waddr = node_reg;
        solid_wdata = 1'b0;
        mat_we      = 1'b0;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    x_next     = in_x;
                    y_next     = in_y;
                    z_next     = in_z;
                    mat_next   = in_mat;
                    level_next = eff_depth - LW'(1);
                    node_next  = '0;
                    fresh_next = 1'b0;
                    added_next = '0;
                    leaf_next  = '0;
                    state_next = S_DONE;
                    if (s_axis_tuser == ovi_pkg::CMD_CLEAR)
                    begin
                        next_free_next = UW'(1);
                        root_occ_next  = 8'd0;
                        solid_we       = 1'b1;
                        solid_waddr    = '0;
                        solid_wdata    = 1'b0;
                        status_next    = ovi_pkg::ST_CLEARED;
                    end
                    else if (!in_range)
                    begin
                        status_next = ovi_pkg::ST_RANGE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (fresh_reg)
                begin
                    occ_we    = 1'b1;
                    occ_waddr = node_reg;
                    occ_wdata = 8'd0;
                end
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                fresh_next = 1'b0;
                if (occ_cur[octant])
                begin
                    node_next = child_rd;
                end
                else if (next_free_reg >= UW'(ovi_pkg::NODE_COUNT))
                begin
                    status_next = ovi_pkg::ST_FULL;
                    leaf_next   = '0;
                end
                else
                begin
                    node_next      = new_node;
                    fresh_next     = 1'b1;
                    next_free_next = next_free_reg + UW'(1);
                    added_next     = added_reg + AW'(1);
                    link_we        = 1'b1;
                    occ_we         = 1'b1;
                    occ_waddr      = node_reg;
                    occ_wdata      = occ_cur | oct_bit;
                    solid_we       = 1'b1;
                    solid_waddr    = new_node;
                    solid_wdata    = 1'b0;
                    if (node_reg == '0)
                        root_occ_next = occ_cur | oct_bit;
                end

                if (!occ_cur[octant] && next_free_reg >= UW'(ovi_pkg::NODE_COUNT))
                    state_next = S_DONE;
                else if (level_reg == '0)
                    state_next = S_MARK;
                else
                begin
                    level_next = level_reg - LW'(1);
                    state_next = S_READ;
                end
            end
            S_MARK:
            begin
                if (fresh_reg)
                begin
                    occ_we    = 1'b1;
                    occ_waddr = node_reg;
                    occ_wdata = 8'd0;
                end
                fresh_next  = 1'b0;
                solid_we    = 1'b1;
                solid_waddr = node_reg;
                solid_wdata = 1'b1;
                mat_we      = 1'b1;
                status_next = ovi_pkg::ST_MARKED;
                leaf_next   = node_reg;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = status_reg;
                    out_data_next  = ovi_pkg::M_DATA_W'({next_free_reg, added_reg, leaf_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= ovi_pkg::DEPTH_RESET;
            level_reg     <= '0;
            node_reg      <= '0;
            fresh_reg     <= 1'b0;
            added_reg     <= '0;
            next_free_reg <= UW'(1);
            root_occ_reg  <= 8'd0;
            status_reg    <= ovi_pkg::ST_MARKED;
            leaf_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_user_reg  <= ovi_pkg::ST_MARKED;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
                depth_reg <= cfg_wr_data;
            level_reg     <= level_next;
            node_reg      <= node_next;
            fresh_reg     <= fresh_next;
            added_reg     <= added_next;
            next_free_reg <= next_free_next;
            root_occ_reg  <= root_occ_next;
            status_reg    <= status_next;
            leaf_reg      <= leaf_next;
            out_valid_reg <= out_valid_next;
            out_user_reg  <= out_user_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        mat_reg      <= mat_next;
        out_data_reg <= out_data_next;
    end

    // node memories: one write per cycle; occ and child have a registered read
    always_ff @(posedge clk)
    begin
        if (occ_we)
            occ_mem[occ_waddr] <= occ_wdata;
        occ_rd <= occ_mem[node_reg];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            child_mem[{node_reg, octant}] <= new_node;
        child_rd <= child_mem[{node_reg, octant}];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            parent_mem[new_node] <= node_reg;
    end

    always_ff @(posedge clk)
    begin
        if (solid_we)
            solid_mem[solid_waddr] <= solid_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
            material_mem[node_reg] <= mat_reg;
    end

endmodule
